/* src/ujse_pkg.sv */
// ----------------------------------------------------------------------------
// ujse_pkg
// Shared types, codes and helpers for the UTF-8 to JSON string escaper.
// ----------------------------------------------------------------------------
`default_nettype none

package ujse_pkg;

    // body kind of one job
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_NONE = 3'd0;  // no body characters
    localparam t_kind KIND_LIT  = 3'd1;  // one character as is
    localparam t_kind KIND_ESC  = 3'd2;  // backslash and one character
    localparam t_kind KIND_U16  = 3'd3;  // one \uXXXX
    localparam t_kind KIND_PAIR = 3'd4;  // surrogate pair, two \uXXXX

    // trailing character of one job
    typedef logic [1:0] t_close;
    localparam t_close CLOSE_NONE  = 2'd0;
    localparam t_close CLOSE_QUOTE = 2'd1;
    localparam t_close CLOSE_BAD   = 2'd2;

    // ascii characters used by the escaper
    localparam logic [6:0] CH_NUL    = 7'h00;
    localparam logic [6:0] CH_QUOTE  = 7'h22;
    localparam logic [6:0] CH_SLASH  = 7'h2F;
    localparam logic [6:0] CH_BSLASH = 7'h5C;
    localparam logic [6:0] CH_LOW_B  = 7'h62;
    localparam logic [6:0] CH_LOW_F  = 7'h66;
    localparam logic [6:0] CH_LOW_N  = 7'h6E;
    localparam logic [6:0] CH_LOW_R  = 7'h72;
    localparam logic [6:0] CH_LOW_T  = 7'h74;
    localparam logic [6:0] CH_LOW_U  = 7'h75;

    // code point limits
    localparam logic [20:0] CP_BMP_END = 21'h10000;
    localparam logic [20:0] CP_MAX     = 21'h10FFFF;

    // one classified byte, waiting for expansion
    typedef struct packed {
        logic        open;    // opening quote first
        t_kind       kind;
        t_close      close;
        logic [19:0] pay;     // char, u16 value, or code point minus 0x10000
    } t_job;

    // lowercase hex digit
    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] r;
        if (nib < 4'd10) begin
            r = 7'h30 + {3'b000, nib};
        end else begin
            r = 7'h57 + {3'b000, nib};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/ujse_front.sv */
// ----------------------------------------------------------------------------
// ujse_front
// Accepts input bytes, runs the UTF-8 decoder and validator, and turns each
// byte into one job descriptor for the expansion stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ujse_front
    import ujse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_first_byte,
    input  wire logic       i_last_byte,
    input  wire logic       i_empty_string,
    output t_job            o_job,
    output logic            o_push
);

    logic [7:0]  r_lead,  n_lead;
    logic [20:0] r_acc,   n_acc;
    logic [1:0]  r_rem,   n_rem;
    logic [1:0]  r_seen,  n_seen;
    logic        r_fail,  n_fail;

    logic [7:0]  s_lead;
    logic [20:0] s_acc;
    logic [1:0]  s_rem;
    logic [1:0]  s_seen;
    logic        s_fail;
    logic [20:0] acc_nx;
    logic [20:0] cp_off;
    logic [1:0]  rem_dec;
    logic [6:0]  esc;
    logic [7:0]  b;
    t_job        job;

    assign b       = i_data_byte;
    assign acc_nx  = {s_acc[14:0], b[5:0]};
    assign cp_off  = acc_nx - CP_BMP_END;
    assign rem_dec = s_rem - 2'd1;

    // short escapes for ascii bytes
    always_comb begin
        unique case (b)
            8'h22:   esc = CH_QUOTE;
            8'h5C:   esc = CH_BSLASH;
            8'h2F:   esc = CH_SLASH;
            8'h08:   esc = CH_LOW_B;
            8'h0C:   esc = CH_LOW_F;
            8'h0A:   esc = CH_LOW_N;
            8'h0D:   esc = CH_LOW_R;
            8'h09:   esc = CH_LOW_T;
            default: esc = CH_NUL;
        endcase
    end

    // decode one byte against the current sequence state
    always_comb begin
        // first byte of a string starts from a clean state
        s_lead = i_first_byte ? 8'd0  : r_lead;
        s_acc  = i_first_byte ? 21'd0 : r_acc;
        s_rem  = i_first_byte ? 2'd0  : r_rem;
        s_seen = i_first_byte ? 2'd0  : r_seen;
        s_fail = i_first_byte ? 1'b0  : r_fail;

        n_lead = s_lead;
        n_acc  = s_acc;
        n_rem  = s_rem;
        n_seen = s_seen;
        n_fail = s_fail;

        job.open  = i_first_byte;
        job.kind  = KIND_NONE;
        job.close = CLOSE_NONE;
        job.pay   = 20'd0;

        if (!s_fail) begin
            if (s_rem == 2'd0) begin
                if (!b[7]) begin
                    // plain ascii
                    if (esc != CH_NUL) begin
                        job.kind = KIND_ESC;
                        job.pay  = {13'd0, esc};
                    end else if (b < 8'h20) begin
                        job.kind = KIND_U16;
                        job.pay  = {12'd0, b};
                    end else begin
                        job.kind = KIND_LIT;
                        job.pay  = {12'd0, b};
                    end
                end else if (!b[6]) begin
                    // stray continuation byte
                    n_fail = 1'b1;
                end else begin
                    n_lead = b;
                    n_seen = 2'd0;
                    if (!b[5]) begin
                        if (b[4:1] == 4'd0) begin
                            n_fail = 1'b1;
                        end else begin
                            n_acc = {16'd0, b[4:0]};
                            n_rem = 2'd1;
                        end
                    end else if (!b[4]) begin
                        n_acc = {17'd0, b[3:0]};
                        n_rem = 2'd2;
                    end else if (!b[3]) begin
                        n_acc = {18'd0, b[2:0]};
                        n_rem = 2'd3;
                    end else begin
                        n_fail = 1'b1;
                    end
                end
            end else if (b[7:6] != 2'b10) begin
                // continuation byte missing
                n_fail = 1'b1;
            end else if (s_seen == 2'd0 && s_lead == 8'hE0 && !b[5]) begin
                n_fail = 1'b1;
            end else if (s_seen == 2'd0 && s_lead == 8'hF0 && b[5:4] == 2'b00) begin
                n_fail = 1'b1;
            end else begin
                n_acc  = acc_nx;
                n_rem  = rem_dec;
                n_seen = s_seen + 2'd1;
                if (rem_dec == 2'd0) begin
                    // sequence complete, range checks
                    if (acc_nx < CP_BMP_END) begin
                        if (acc_nx[15:11] == 5'b11011) begin
                            n_fail = 1'b1;
                        end else begin
                            job.kind = KIND_U16;
                            job.pay  = {4'd0, acc_nx[15:0]};
                        end
                    end else if (acc_nx <= CP_MAX) begin
                        job.kind = KIND_PAIR;
                        job.pay  = cp_off[19:0];
                    end else begin
                        n_fail = 1'b1;
                    end
                    n_acc  = 21'd0;
                    n_seen = 2'd0;
                    n_lead = 8'd0;
                end
            end
        end

        // string end closes the literal or reports the failure
        if (i_last_byte) begin
            job.close = (n_fail || n_rem != 2'd0) ? CLOSE_BAD : CLOSE_QUOTE;
        end

        // empty string overrides everything
        if (i_empty_string) begin
            job.open  = 1'b1;
            job.kind  = KIND_NONE;
            job.close = CLOSE_QUOTE;
            job.pay   = 20'd0;
        end

        if (i_last_byte || i_empty_string) begin
            n_lead = 8'd0;
            n_acc  = 21'd0;
            n_rem  = 2'd0;
            n_seen = 2'd0;
            n_fail = 1'b0;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= 8'd0;
            r_acc  <= 21'd0;
            r_rem  <= 2'd0;
            r_seen <= 2'd0;
            r_fail <= 1'b0;
        end else if (i_accept) begin
            r_lead <= n_lead;
            r_acc  <= n_acc;
            r_rem  <= n_rem;
            r_seen <= n_seen;
            r_fail <= n_fail;
        end
    end

    // jobs with no characters are dropped here
    assign o_job  = job;
    assign o_push = i_accept &&
                    (job.open || job.kind != KIND_NONE || job.close != CLOSE_NONE);

endmodule

`default_nettype wire

/* src/ujse_queue.sv */
// ----------------------------------------------------------------------------
// ujse_queue
// Short job queue between the decoder and the expansion stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ujse_queue
    import ujse_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    input  wire logic i_pop,
    output t_job      o_head,
    output logic      o_nonempty,
    output logic      o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [PW-1:0]   r_wptr, n_wptr;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_cnt,  n_cnt;

    assign o_head     = r_mem[r_rptr];
    assign o_nonempty = (r_cnt != '0);
    assign o_full     = (r_cnt == CW'(DEPTH));

    // pointer and count update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // job storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

/* src/ujse_back.sv */
// ----------------------------------------------------------------------------
// ujse_back
// Expands the job at the queue head into output characters, one per cycle
// while the output is not stalled, into a registered output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module ujse_back
    import ujse_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_job            i_head,
    input  wire logic       i_nonempty,
    output logic            o_pop,
    input  wire logic       i_stall,
    output logic            o_valid,
    output logic [6:0]      o_out_char,
    output logic            o_last_char,
    output logic            o_invalid
);

    logic [3:0]  r_step, n_step;
    logic        r_valid;
    logic [6:0]  r_char;
    logic        r_last;
    logic        r_inv;

    logic        out_free;
    logic        produce;
    logic        final_step;
    logic [3:0]  nbody;
    logic [3:0]  total;
    logic [3:0]  body_idx;
    logic        grp;
    logic [3:0]  pos;
    logic [15:0] word;
    logic [6:0]  ch;
    logic        ch_last;
    logic        ch_inv;

    assign out_free = !r_valid || !i_stall;
    assign produce  = i_nonempty && out_free;

    // character count of the job body
    always_comb begin
        unique case (i_head.kind)
            KIND_LIT:  nbody = 4'd1;
            KIND_ESC:  nbody = 4'd2;
            KIND_U16:  nbody = 4'd6;
            KIND_PAIR: nbody = 4'd12;
            default:   nbody = 4'd0;
        endcase
    end

    assign total      = {3'd0, i_head.open} + nbody +
                        {3'd0, (i_head.close != CLOSE_NONE)};
    assign final_step = (r_step == total - 4'd1);
    assign body_idx   = r_step - {3'd0, i_head.open};
    assign grp        = (body_idx >= 4'd6);
    assign pos        = grp ? body_idx - 4'd6 : body_idx;

    // 16-bit unit for the \u form
    always_comb begin
        if (i_head.kind == KIND_PAIR) begin
            word = grp ? {6'b110111, i_head.pay[9:0]} : {6'b110110, i_head.pay[19:10]};
        end else begin
            word = i_head.pay[15:0];
        end
    end

    // character for the current step
    always_comb begin
        ch      = CH_NUL;
        ch_last = 1'b0;
        ch_inv  = 1'b0;
        if (i_head.open && r_step == 4'd0) begin
            ch = CH_QUOTE;
        end else if (body_idx < nbody) begin
            unique case (i_head.kind)
                KIND_LIT: ch = i_head.pay[6:0];
                KIND_ESC: ch = (body_idx == 4'd0) ? CH_BSLASH : i_head.pay[6:0];
                default: begin
                    unique case (pos)
                        4'd0:    ch = CH_BSLASH;
                        4'd1:    ch = CH_LOW_U;
                        4'd2:    ch = hex_char(word[15:12]);
                        4'd3:    ch = hex_char(word[11:8]);
                        4'd4:    ch = hex_char(word[7:4]);
                        default: ch = hex_char(word[3:0]);
                    endcase
                end
            endcase
        end else begin
            ch_last = 1'b1;
            ch_inv  = (i_head.close == CLOSE_BAD);
            ch      = ch_inv ? CH_NUL : CH_QUOTE;
        end
    end

    // step through the job, pop after its final character
    assign o_pop  = produce && final_step;
    assign n_step = o_pop ? 4'd0 : r_step + 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            if (produce) begin
                r_step <= n_step;
            end
            if (out_free) begin
                r_valid <= produce;
            end
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_char <= ch;
            r_last <= ch_last;
            r_inv  <= ch_inv;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;
    assign o_invalid   = r_inv;

endmodule

`default_nettype wire

/* src/utf8_json_string_escaper_top.sv */
// ----------------------------------------------------------------------------
// utf8_json_string_escaper_top
// UTF-8 string to quoted ASCII JSON string literal, with validation.
// ----------------------------------------------------------------------------
// The decoder takes one input beat per cycle as long as its job queue
// (QUEUE_DEPTH entries) has room. Each byte that yields characters becomes
// one job, and the expansion stage drains jobs at one output character per
// cycle while the output is not stalled. A byte produces 1 character for
// plain ASCII, 2 for short escapes, 6 for \uXXXX, 12 for a surrogate pair,
// plus one each for the opening and closing quote. The output port, one
// character per cycle unless stalled, sets the sustained rate; with an empty
// queue the first character of a byte is written into the queue, then into
// the registered output beat. Bad UTF-8 gives a single beat with invalid set
// on the string's last byte, after whatever characters were already sent
// for that string.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_json_string_escaper_top
    import ujse_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // input channel
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_first_byte,
    input  wire logic       i_last_byte,
    input  wire logic       i_empty_string,
    // output channel
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [6:0]      o_out_char,
    output logic            o_last_char,
    output logic            o_invalid
);

    t_job  push_job;
    t_job  head_job;
    logic  push;
    logic  pop;
    logic  nonempty;
    logic  full;
    logic  accept;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    // decoder and classifier
    ujse_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_first_byte   (i_first_byte),
        .i_last_byte    (i_last_byte),
        .i_empty_string (i_empty_string),
        .o_job          (push_job),
        .o_push         (push)
    );

    // job queue
    ujse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (push_job),
        .i_pop      (pop),
        .o_head     (head_job),
        .o_nonempty (nonempty),
        .o_full     (full)
    );

    // character expansion
    ujse_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_job),
        .i_nonempty  (nonempty),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char),
        .o_invalid   (o_invalid)
    );

endmodule

`default_nettype wire
